// ===== rtl/core/sdci_pkg.sv =====
`timescale 1ns / 1ps
package sdci_pkg;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  rx_byte;
    logic [22:0] block_number;
  } in_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        last;
    logic [4:0]  expect_len;
    logic [7:0]  clock_div;
    logic        init_done;
    logic        init_failed;
    logic [15:0] card_address;
  } out_t;

  localparam logic [1:0] ACT_START   = 2'd0;
  localparam logic [1:0] ACT_RESP    = 2'd1;
  localparam logic [1:0] ACT_TIMEOUT = 2'd2;
  localparam logic [1:0] ACT_READ    = 2'd3;

  localparam logic [1:0] RUN_STATUS = 2'd0;
  localparam logic [1:0] RUN_START  = 2'd1;
  localparam logic [1:0] RUN_FRAME  = 2'd2;

  localparam logic CFG_INIT_DIV = 1'b0;
  localparam logic CFG_RUN_DIV  = 1'b1;

  localparam logic [7:0]  INIT_DIV_RESET = 8'd250;
  localparam logic [7:0]  RUN_DIV_RESET  = 8'd3;
  localparam logic [7:0]  CMD_START_BITS = 8'h40;
  localparam logic [6:0]  CRC7_POLY      = 7'h09;
  localparam logic [31:0] CMD8_ARG       = 32'h0000_01AA;
  localparam logic [31:0] ACMD41_ARG     = 32'h0030_0000;
  localparam logic [31:0] ACMD6_ARG      = 32'h0000_0002;
  localparam logic [4:0]  RESP_LEN       = 5'd6;
  localparam logic [4:0]  RESP_LEN_CID   = 5'd17;

  localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0] CMD_ALL_CID   = 6'd2;
  localparam logic [5:0] CMD_SEND_RCA  = 6'd3;
  localparam logic [5:0] CMD_SET_BUS   = 6'd6;
  localparam logic [5:0] CMD_SELECT    = 6'd7;
  localparam logic [5:0] CMD_IF_COND   = 6'd8;
  localparam logic [5:0] CMD_READ      = 6'd17;
  localparam logic [5:0] CMD_OP_COND   = 6'd41;
  localparam logic [5:0] CMD_APP       = 6'd55;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [5:0]  idx;
    logic [31:0] arg;
    logic [4:0]  expect_len;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  clock_div;
    logic        init_done;
    logic        init_failed;
    logic [15:0] card_address;
  } status_t;

endpackage

// ===== rtl/core/sdci_frame.sv =====
`timescale 1ns / 1ps
module sdci_frame (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sdci_pkg::cmd_t    cmd_i,
  input  sdci_pkg::status_t status_i,
  output logic             busy_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sdci_pkg::out_t    out_data_o
);
  import sdci_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOAD  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_SEND  = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [1:0]  kind_q, kind_d;
  logic [5:0]  idx_q, idx_d;
  logic [31:0] arg_q, arg_d;
  logic [4:0]  exp_q, exp_d;
  logic [3:0]  pos_q, pos_d;
  logic [2:0]  bit_q, bit_d;
  logic [6:0]  crc_q, crc_d;

  logic        second, dummy, need_shift, at_last, fbk;
  logic [3:0]  fb_wide, last_pos;
  logic [2:0]  fb;
  logic [5:0]  cur_idx;
  logic [31:0] cur_arg;
  logic [7:0]  byte_val, tx_byte;
  logic [6:0]  crc_in, crc_nx;

  always_comb begin
    second  = (kind_q == RUN_START) && (pos_q >= 4'd7);
    dummy   = (kind_q == RUN_START) && (pos_q == 4'd6);
    fb_wide = second ? (pos_q - 4'd7) : pos_q;
    fb      = fb_wide[2:0];
    if (kind_q == RUN_START) begin
      cur_idx = second ? CMD_IF_COND : CMD_GO_IDLE;
      cur_arg = second ? CMD8_ARG : 32'd0;
    end else begin
      cur_idx = idx_q;
      cur_arg = arg_q;
    end
    case (kind_q)
      RUN_START: last_pos = 4'd12;
      RUN_FRAME: last_pos = 4'd5;
      default:   last_pos = 4'd0;
    endcase
    at_last = (pos_q == last_pos);
    case (fb)
      3'd0:    byte_val = CMD_START_BITS | {2'b00, cur_idx};
      3'd1:    byte_val = cur_arg[31:24];
      3'd2:    byte_val = cur_arg[23:16];
      3'd3:    byte_val = cur_arg[15:8];
      3'd4:    byte_val = cur_arg[7:0];
      default: byte_val = {crc_q, 1'b1};
    endcase
    if (kind_q == RUN_STATUS) begin
      tx_byte = 8'd0;
    end else if (dummy) begin
      tx_byte = 8'hFF;
    end else begin
      tx_byte = byte_val;
    end
    need_shift = (kind_q != RUN_STATUS) && !dummy && (fb < 3'd5);
    crc_in = ((fb == 3'd0) && (bit_q == 3'd0)) ? 7'd0 : crc_q;
    fbk    = byte_val[~bit_q] ^ crc_in[6];
    crc_nx = {crc_in[5:0], 1'b0} ^ (fbk ? CRC7_POLY : 7'd0);
  end

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    idx_d   = idx_q;
    arg_d   = arg_q;
    exp_d   = exp_q;
    pos_d   = pos_q;
    bit_d   = bit_q;
    crc_d   = crc_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          kind_d  = cmd_i.kind;
          idx_d   = cmd_i.idx;
          arg_d   = cmd_i.arg;
          exp_d   = cmd_i.expect_len;
          pos_d   = 4'd0;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        bit_d   = 3'd0;
        state_d = need_shift ? S_SHIFT : S_SEND;
      end
      S_SHIFT: begin
        crc_d = crc_nx;
        bit_d = bit_q + 3'd1;
        if (bit_q == 3'd7) begin
          state_d = S_SEND;
        end
      end
      S_SEND: begin
        if (out_ready_i) begin
          if (at_last) begin
            state_d = S_IDLE;
          end else begin
            pos_d   = pos_q + 4'd1;
            state_d = S_LOAD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= RUN_STATUS;
      pos_q   <= 4'd0;
      bit_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      pos_q   <= pos_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    arg_q <= arg_d;
    exp_q <= exp_d;
    crc_q <= crc_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_SEND);

  always_comb begin
    out_data_o.tx_valid     = (kind_q != RUN_STATUS);
    out_data_o.tx_byte      = tx_byte;
    out_data_o.last         = at_last;
    out_data_o.expect_len   = at_last ? exp_q : 5'd0;
    out_data_o.clock_div    = status_i.clock_div;
    out_data_o.init_done    = status_i.init_done;
    out_data_o.init_failed  = status_i.init_failed;
    out_data_o.card_address = status_i.card_address;
  end

endmodule

// ===== rtl/core/sdci_ctrl.sv =====
`timescale 1ns / 1ps
module sdci_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sdci_pkg::in_t     in_data_i,
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [7:0]       cfg_data_i,
  input  logic             busy_i,
  output sdci_pkg::cmd_t    cmd_o,
  output sdci_pkg::status_t status_o
);
  import sdci_pkg::*;

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_W8     = 4'd1;
  localparam logic [3:0] PH_W55A   = 4'd2;
  localparam logic [3:0] PH_W41    = 4'd3;
  localparam logic [3:0] PH_W2     = 4'd4;
  localparam logic [3:0] PH_W3     = 4'd5;
  localparam logic [3:0] PH_W7     = 4'd6;
  localparam logic [3:0] PH_W55B   = 4'd7;
  localparam logic [3:0] PH_W6     = 4'd8;
  localparam logic [3:0] PH_READY  = 4'd9;
  localparam logic [3:0] PH_WREAD  = 4'd10;
  localparam logic [3:0] PH_FAILED = 4'd11;

  logic [3:0]  phase_q, phase_d;
  logic [4:0]  br_q, br_d, br_inc, need;
  logic [7:0]  r1_q, r1_d, r2_q, r2_d;
  logic [15:0] rca_q, rca_d;
  logic        sel_q, sel_d, done_q, done_d, fail_q, fail_d;
  logic [7:0]  init_div_q, run_div_q, div;
  cmd_t        cmd_q, cmd_d;
  logic        accept, waiting;

  assign in_ready_o = !busy_i && !cmd_q.valid;
  assign accept     = in_valid_i && in_ready_o;
  assign waiting    = (phase_q >= PH_W8) && (phase_q <= PH_WREAD) && (phase_q != PH_READY);
  assign need       = (phase_q == PH_W2) ? RESP_LEN_CID : RESP_LEN;
  assign br_inc     = br_q + 5'd1;

  always_comb begin
    phase_d = phase_q;
    br_d    = br_q;
    r1_d    = r1_q;
    r2_d    = r2_q;
    rca_d   = rca_q;
    sel_d   = sel_q;
    done_d  = done_q;
    fail_d  = fail_q;
    cmd_d   = '0;
    if (accept) begin
      cmd_d.valid = 1'b1;
      cmd_d.kind  = RUN_STATUS;
      case (in_data_i.action)
        ACT_START: begin
          done_d  = 1'b0;
          fail_d  = 1'b0;
          rca_d   = 16'd0;
          sel_d   = 1'b0;
          r1_d    = 8'd0;
          r2_d    = 8'd0;
          phase_d = PH_W8;
          br_d    = 5'd0;
          cmd_d.kind       = RUN_START;
          cmd_d.expect_len = RESP_LEN;
        end
        ACT_RESP: begin
          if (waiting) begin
            if (br_q == 5'd1) r1_d = in_data_i.rx_byte;
            if (br_q == 5'd2) r2_d = in_data_i.rx_byte;
            br_d = br_inc;
            if (br_inc >= need) begin
              br_d             = 5'd0;
              cmd_d.kind       = RUN_FRAME;
              cmd_d.expect_len = RESP_LEN;
              case (phase_q)
                PH_W8: begin
                  cmd_d.idx = CMD_APP;
                  phase_d   = PH_W55A;
                end
                PH_W55A: begin
                  cmd_d.idx = CMD_OP_COND;
                  cmd_d.arg = ACMD41_ARG;
                  phase_d   = PH_W41;
                end
                PH_W41: begin
                  if (r1_q[7]) begin
                    cmd_d.idx        = CMD_ALL_CID;
                    cmd_d.expect_len = RESP_LEN_CID;
                    phase_d          = PH_W2;
                  end else begin
                    cmd_d.idx = CMD_APP;
                    phase_d   = PH_W55A;
                  end
                end
                PH_W2: begin
                  cmd_d.idx = CMD_SEND_RCA;
                  phase_d   = PH_W3;
                end
                PH_W3: begin
                  rca_d     = {r1_q, r2_q};
                  cmd_d.idx = CMD_SELECT;
                  cmd_d.arg = {r1_q, r2_q, 16'd0};
                  phase_d   = PH_W7;
                end
                PH_W7: begin
                  cmd_d.idx = CMD_APP;
                  cmd_d.arg = {rca_q, 16'd0};
                  phase_d   = PH_W55B;
                end
                PH_W55B: begin
                  cmd_d.idx = CMD_SET_BUS;
                  cmd_d.arg = ACMD6_ARG;
                  phase_d   = PH_W6;
                end
                PH_W6: begin
                  cmd_d.kind       = RUN_STATUS;
                  cmd_d.expect_len = 5'd0;
                  sel_d            = 1'b1;
                  done_d           = 1'b1;
                  phase_d          = PH_READY;
                end
                default: begin
                  cmd_d.kind       = RUN_STATUS;
                  cmd_d.expect_len = 5'd0;
                  phase_d          = PH_READY;
                end
              endcase
            end
          end
        end
        ACT_TIMEOUT: begin
          if (phase_q == PH_WREAD) begin
            phase_d = PH_READY;
            br_d    = 5'd0;
          end else if (waiting) begin
            fail_d  = 1'b1;
            phase_d = PH_FAILED;
            br_d    = 5'd0;
          end
        end
        default: begin
          if (phase_q == PH_READY) begin
            cmd_d.kind       = RUN_FRAME;
            cmd_d.idx        = CMD_READ;
            cmd_d.arg        = {in_data_i.block_number, 9'd0};
            cmd_d.expect_len = RESP_LEN;
            phase_d          = PH_WREAD;
            br_d             = 5'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      br_q       <= 5'd0;
      r1_q       <= 8'd0;
      r2_q       <= 8'd0;
      rca_q      <= 16'd0;
      sel_q      <= 1'b0;
      done_q     <= 1'b0;
      fail_q     <= 1'b0;
      cmd_q      <= '0;
      init_div_q <= INIT_DIV_RESET;
      run_div_q  <= RUN_DIV_RESET;
    end else begin
      phase_q <= phase_d;
      br_q    <= br_d;
      r1_q    <= r1_d;
      r2_q    <= r2_d;
      rca_q   <= rca_d;
      sel_q   <= sel_d;
      done_q  <= done_d;
      fail_q  <= fail_d;
      cmd_q   <= cmd_d;
      if (cfg_we_i && (cfg_index_i == CFG_INIT_DIV)) init_div_q <= cfg_data_i;
      if (cfg_we_i && (cfg_index_i == CFG_RUN_DIV))  run_div_q  <= cfg_data_i;
    end
  end

  always_comb begin
    div = sel_q ? run_div_q : init_div_q;
    if (div == 8'd0) div = 8'd1;
  end

  assign cmd_o                 = cmd_q;
  assign status_o.clock_div    = div;
  assign status_o.init_done    = done_q;
  assign status_o.init_failed  = fail_q;
  assign status_o.card_address = rca_q;

endmodule

// ===== rtl/core/sd_card_init_command_sequencer.sv =====
`timescale 1ns / 1ps
// SD native-mode bring-up sequencer. Each accepted event yields a run of result
// transfers ending with last set: command frame bytes (CRC7 appended), the
// 0xFF dummy after CMD0, or one status-only transfer when nothing is sent.
// The accepted event is registered as a command before the frame unit loads it.
// Frame bytes 0 to 4 each pass through a load state and the bit-serial CRC7
// unit before they are offered; dummy, CRC and status transfers are offered
// straight after their load state. A new event is accepted only after the
// whole run of the previous one has transferred and the frame unit is idle.
// Divider registers are written through the plain write port.
module sd_card_init_command_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sdci_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output sdci_pkg::out_t  out_data_o,
  input  logic            cfg_we_i,
  input  logic            cfg_index_i,
  input  logic [7:0]      cfg_data_i
);
  import sdci_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    busy;

  sdci_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .busy_i      (busy),
    .cmd_o       (cmd),
    .status_o    (status)
  );

  sdci_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_i    (status),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
